@@ hw/rtl/rra_pkg.sv @@
// rra_pkg: shared types, widths and defaults for the ring record allocator.
// Used by the channel interfaces, the controller, the datapath and the top level.
// No dependencies.
package rra_pkg;

  // Default build parameters
  localparam int unsigned RING_BYTES_DEF   = 65536;
  localparam int unsigned ALIGN_BYTES_DEF  = 32;
  localparam int unsigned HEADER_BYTES_DEF = 32;
  localparam int unsigned MAX_RECORDS_DEF  = 2048;

  // Fixed field widths
  localparam int unsigned OP_W   = 2;
  localparam int unsigned LEN_W  = 16;
  localparam int unsigned OFS_W  = 16;
  localparam int unsigned SIZE_W = 17;  // rounded record size, used bytes, ring size
  localparam int unsigned CNT_W  = 12;  // record count as reported

  localparam logic [SIZE_W-1:0] RING_SIZE_RST = SIZE_W'(65536);

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_SHRINK  = 2'd1,
    OP_RELEASE = 2'd2,
    OP_NONE    = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_BAD_NAME = 2'd2,
    ST_GROWS    = 2'd3
  } status_t;

  // Controller to datapath
  typedef struct packed {
    logic sample;  // register the deque end entries from memory
    logic accept;  // input beat taken this cycle
    logic commit;  // execute the held request and load the result register
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_valid;  // result register holds a beat not yet taken
  } dp_stat_t;

endpackage

@@ hw/rtl/rra_in_if.sv @@
// rra_in_if: request channel of the ring record allocator.
// Depends on rra_pkg for field widths.
interface rra_in_if;
  logic                         valid;
  logic                         ready;
  logic [rra_pkg::OP_W-1:0]     opcode;
  logic [rra_pkg::LEN_W-1:0]    length;
  logic [rra_pkg::OFS_W-1:0]    payload_offset;

  modport source (output valid, output opcode, output length, output payload_offset,
                  input ready);
  modport sink   (input valid, input opcode, input length, input payload_offset,
                  output ready);
endinterface

@@ hw/rtl/rra_out_if.sv @@
// rra_out_if: result channel of the ring record allocator.
// Depends on rra_pkg for field widths.
interface rra_out_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   status;
  logic [rra_pkg::OFS_W-1:0]    granted_offset;
  logic [rra_pkg::SIZE_W-1:0]   used_bytes;
  logic [rra_pkg::CNT_W-1:0]    record_count;

  modport source (output valid, output status, output granted_offset, output used_bytes,
                  output record_count, input ready);
  modport sink   (input valid, input status, input granted_offset, input used_bytes,
                  input record_count, output ready);
endinterface

@@ hw/rtl/rra_ctrl.sv @@
// rra_ctrl: two-state sequencer of the ring record allocator.
// Depends on rra_pkg (ctl_cmd_t, dp_stat_t).
module rra_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_ready,
  input  rra_pkg::dp_stat_t stat,
  output rra_pkg::ctl_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  // Commands
  always_comb begin
    cmd.sample = (state_r == S_IDLE);
    cmd.accept = (state_r == S_IDLE) && in_valid;
    cmd.commit = (state_r == S_EXEC) && (!stat.out_valid || out_ready);
    in_ready   = (state_r == S_IDLE);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_EXEC;
      S_EXEC: if (cmd.commit) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ hw/rtl/rra_dpath.sv @@
// rra_dpath: record deque memory, end pointers, byte count and placement logic.
// Depends on rra_pkg; driven by rra_ctrl through ctl_cmd_t.
module rra_dpath #(
  parameter int unsigned RING_BYTES   = rra_pkg::RING_BYTES_DEF,
  parameter int unsigned ALIGN_BYTES  = rra_pkg::ALIGN_BYTES_DEF,
  parameter int unsigned HEADER_BYTES = rra_pkg::HEADER_BYTES_DEF,
  parameter int unsigned MAX_RECORDS  = rra_pkg::MAX_RECORDS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rra_pkg::ctl_cmd_t            cmd,
  output rra_pkg::dp_stat_t            stat,
  // config
  input  logic                         cfg_we,
  input  logic [rra_pkg::SIZE_W-1:0]   cfg_wdata,
  // request payload
  input  logic [rra_pkg::OP_W-1:0]     in_opcode,
  input  logic [rra_pkg::LEN_W-1:0]    in_length,
  input  logic [rra_pkg::OFS_W-1:0]    in_payload_offset,
  // result
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [1:0]                   out_status,
  output logic [rra_pkg::OFS_W-1:0]    out_granted_offset,
  output logic [rra_pkg::SIZE_W-1:0]   out_used_bytes,
  output logic [rra_pkg::CNT_W-1:0]    out_record_count
);

  localparam int unsigned SW = rra_pkg::SIZE_W;
  localparam int unsigned OW = rra_pkg::OFS_W;
  localparam int unsigned AW = $clog2(RING_BYTES);          // record start
  localparam int unsigned IW = $clog2(MAX_RECORDS);         // slot index
  localparam int unsigned CW = $clog2(MAX_RECORDS + 1);     // live count
  localparam int unsigned EW = ((AW > SW) ? AW : SW) + 2;   // placement arithmetic
  localparam int unsigned DW = AW + SW;                     // memory word {start, size}

  // Rounding by reciprocal: q = floor(t / ALIGN) exact for t < 2^SW
  localparam int unsigned RECIP_SH = SW + 8;
  localparam int unsigned MW       = RECIP_SH - 1;
  localparam int unsigned PW       = SW + MW;
  localparam int unsigned QW       = PW - RECIP_SH;
  localparam logic [MW-1:0] RECIP_M =
    MW'(((64'd1 << RECIP_SH) + 64'(ALIGN_BYTES) - 64'd1) / 64'(ALIGN_BYTES));

  function automatic logic [IW-1:0] slot_inc(input logic [IW-1:0] s);
    return (s == IW'(MAX_RECORDS - 1)) ? '0 : s + IW'(1);
  endfunction

  function automatic logic [IW-1:0] slot_dec(input logic [IW-1:0] s);
    return (s == '0) ? IW'(MAX_RECORDS - 1) : s - IW'(1);
  endfunction

  // Deque storage
  logic [DW-1:0] mem [MAX_RECORDS];
  logic [DW-1:0] rd_old_r, rd_new_r;

  // State
  logic [IW-1:0]  oldest_r, oldest_nxt;
  logic [IW-1:0]  newest_r, newest_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [SW-1:0]  used_r, used_nxt;
  logic [SW-1:0]  ring_size_r;

  // Held request
  rra_pkg::opcode_t op_r;
  logic [OW-1:0]    name_r;
  logic [QW-1:0]    q_r;

  // Result register
  logic             out_valid_r;
  logic [1:0]       status_r;
  logic [OW-1:0]    granted_r;

  // Quotient of the padded length, taken with the input beat
  logic [SW-1:0] pad_len;
  logic [PW-1:0] recip_prod;
  assign pad_len    = SW'(in_length) + SW'(HEADER_BYTES + ALIGN_BYTES - 1);
  assign recip_prod = PW'(pad_len) * PW'(RECIP_M);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r   <= rra_pkg::opcode_t'(in_opcode);
      name_r <= in_payload_offset;
      q_r    <= recip_prod[PW-1:RECIP_SH];
    end
  end

  // Decode the held entries
  logic [AW-1:0] old_start, new_start;
  logic [SW-1:0] old_size, new_size;
  logic [SW-1:0] rsize;
  assign old_start = rd_old_r[DW-1:SW];
  assign old_size  = rd_old_r[SW-1:0];
  assign new_start = rd_new_r[DW-1:SW];
  assign new_size  = rd_new_r[SW-1:0];
  assign rsize     = SW'(SW'(q_r) * SW'(ALIGN_BYTES));

  logic [EW-1:0] eff_size, cand, cand_end, head, r_ext;
  logic [OW-1:0] name_old, name_new;
  assign eff_size = (EW'(ring_size_r) < EW'(RING_BYTES)) ? EW'(ring_size_r) : EW'(RING_BYTES);
  assign head     = EW'(old_start);
  assign r_ext    = EW'(rsize);
  assign cand     = EW'(new_start) + EW'(new_size);
  assign cand_end = cand + r_ext;
  assign name_old = OW'(EW'(old_start) + EW'(HEADER_BYTES));
  assign name_new = OW'(EW'(new_start) + EW'(HEADER_BYTES));

  // Placement of a new record
  logic          fit_ok;
  logic [EW-1:0] fit_start;
  always_comb begin
    fit_ok    = 1'b0;
    fit_start = '0;
    priority if (count_r == CW'(MAX_RECORDS)) begin
      fit_ok = 1'b0;
    end else if (count_r == '0) begin
      fit_ok = (r_ext <= eff_size);
    end else if (head > EW'(new_start)) begin
      // live records wrap: must end before the oldest
      fit_ok    = (cand_end <= head);
      fit_start = cand;
    end else if (cand_end <= eff_size) begin
      fit_ok    = 1'b1;
      fit_start = cand;
    end else if (r_ext < head) begin
      fit_ok = 1'b1;
    end else begin
      fit_ok = 1'b0;
    end
  end

  // Request execution
  rra_pkg::status_t status_nxt;
  logic [OW-1:0]    granted_nxt;
  logic             mem_we;
  logic [IW-1:0]    mem_waddr;
  logic [DW-1:0]    mem_wdata;
  always_comb begin
    status_nxt  = rra_pkg::ST_OK;
    granted_nxt = '0;
    used_nxt    = used_r;
    count_nxt   = count_r;
    oldest_nxt  = oldest_r;
    newest_nxt  = newest_r;
    mem_we      = 1'b0;
    mem_waddr   = newest_r;
    mem_wdata   = {new_start, rsize};
    unique case (op_r)
      rra_pkg::OP_ALLOC: begin
        if (fit_ok) begin
          mem_we      = 1'b1;
          mem_waddr   = (count_r == '0) ? oldest_r : slot_inc(newest_r);
          mem_wdata   = {fit_start[AW-1:0], rsize};
          newest_nxt  = mem_waddr;
          count_nxt   = count_r + CW'(1);
          used_nxt    = used_r + rsize;
          granted_nxt = OW'(fit_start + EW'(HEADER_BYTES));
        end else begin
          status_nxt = rra_pkg::ST_NO_SPACE;
        end
      end
      rra_pkg::OP_SHRINK: begin
        priority if (count_r == '0) begin
          status_nxt = rra_pkg::ST_BAD_NAME;
        end else if (name_new != name_r) begin
          status_nxt = rra_pkg::ST_BAD_NAME;
        end else if (rsize > new_size) begin
          status_nxt = rra_pkg::ST_GROWS;
        end else begin
          used_nxt = used_r - (new_size - rsize);
          mem_we   = 1'b1;
        end
      end
      rra_pkg::OP_RELEASE: begin
        // oldest end is checked first
        priority if (count_r == '0) begin
          status_nxt = rra_pkg::ST_BAD_NAME;
        end else if (name_old == name_r) begin
          used_nxt   = used_r - old_size;
          oldest_nxt = slot_inc(oldest_r);
          count_nxt  = count_r - CW'(1);
        end else if (name_new == name_r) begin
          used_nxt   = used_r - new_size;
          newest_nxt = slot_dec(newest_r);
          count_nxt  = count_r - CW'(1);
        end else begin
          status_nxt = rra_pkg::ST_BAD_NAME;
        end
        if (count_nxt == '0) oldest_nxt = '0;
      end
      rra_pkg::OP_NONE: begin
      end
      default: begin
      end
    endcase
  end

  // Memory: two registered reads at the deque ends, one write
  always_ff @(posedge clk) begin
    if (cmd.sample) begin
      rd_old_r <= mem[oldest_r];
      rd_new_r <= mem[newest_r];
    end
    if (cmd.commit && mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_r    <= '0;
      newest_r    <= '0;
      count_r     <= '0;
      used_r      <= '0;
      ring_size_r <= rra_pkg::RING_SIZE_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) ring_size_r <= cfg_wdata;
      if (cmd.commit) begin
        oldest_r <= oldest_nxt;
        newest_r <= newest_nxt;
        count_r  <= count_nxt;
        used_r   <= used_nxt;
      end
      out_valid_r <= cmd.commit | (out_valid_r & ~out_ready);
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status_r  <= status_nxt;
      granted_r <= granted_nxt;
    end
  end

  assign stat.out_valid     = out_valid_r;
  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_granted_offset = granted_r;
  assign out_used_bytes     = used_r;
  assign out_record_count   = rra_pkg::CNT_W'(count_r);

endmodule

@@ hw/rtl/ring_record_allocator.sv @@
// Ring record allocator. Each request beat (allocate, shrink newest, release oldest or
// newest) produces exactly one result beat with status, granted payload offset, bytes
// in use and live record count. In the accept cycle the entries at both deque ends are
// read from the record memory into registers; in the execute state that follows, the
// request is executed, the memory written back once and the result register loaded;
// the block then accepts again. A result still waiting on the output holds the execute
// cycle until it goes. The record memory has no reset and no clearing pass; only the
// entries of live records are used.
// Depends on rra_pkg, rra_in_if, rra_out_if, rra_ctrl and rra_dpath.
module ring_record_allocator #(
  parameter int unsigned RING_BYTES   = rra_pkg::RING_BYTES_DEF,
  parameter int unsigned ALIGN_BYTES  = rra_pkg::ALIGN_BYTES_DEF,
  parameter int unsigned HEADER_BYTES = rra_pkg::HEADER_BYTES_DEF,
  parameter int unsigned MAX_RECORDS  = rra_pkg::MAX_RECORDS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  rra_in_if.sink                     in_ch,
  rra_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [rra_pkg::SIZE_W-1:0] cfg_wdata
);

  rra_pkg::ctl_cmd_t cmd;
  rra_pkg::dp_stat_t stat;

  // Sequencer
  rra_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Deque storage and arithmetic
  rra_dpath #(
    .RING_BYTES   (RING_BYTES),
    .ALIGN_BYTES  (ALIGN_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .MAX_RECORDS  (MAX_RECORDS)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_opcode          (in_ch.opcode),
    .in_length          (in_ch.length),
    .in_payload_offset  (in_ch.payload_offset),
    .out_ready          (out_ch.ready),
    .out_valid          (out_ch.valid),
    .out_status         (out_ch.status),
    .out_granted_offset (out_ch.granted_offset),
    .out_used_bytes     (out_ch.used_bytes),
    .out_record_count   (out_ch.record_count)
  );

endmodule

@@ dv/tb_top.sv @@
// tb_top: self-checking testbench for ring_record_allocator. Plans request beats against
// a look-ahead copy of a record-deque model and checks every result beat in order.
// Depends on rra_pkg, rra_in_if, rra_out_if and the ring_record_allocator RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rra_pkg::*;

  localparam int unsigned RING_CAP    = RING_BYTES_DEF;
  localparam int unsigned ALIGN       = ALIGN_BYTES_DEF;
  localparam int unsigned HDR         = HEADER_BYTES_DEF;
  localparam int unsigned SLOTS       = MAX_RECORDS_DEF;
  localparam int          CYCLE_LIMIT = 1_000_000;
  localparam int          HOLD_CYCLES = 300;
  localparam int          MAX_PRINTS  = 100;
  // model copies: PLAN runs ahead while beats are queued, TRACK follows accepted beats
  localparam int          PLAN        = 0;
  localparam int          TRACK       = 1;

  typedef struct {
    opcode_t          op;
    logic [LEN_W-1:0] len;
    logic [OFS_W-1:0] name;
    bit               drain_first;  // hold the beat until every result is back
  } ring_req_t;

  typedef struct packed {
    status_t           status;
    logic [OFS_W-1:0]  granted;
    logic [SIZE_W-1:0] used;
    logic [CNT_W-1:0]  count;
  } ring_result_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [SIZE_W-1:0] cfg_wdata;

  rra_in_if  in_ch ();
  rra_out_if out_ch ();

  ring_record_allocator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // deque model, two copies
  int unsigned rec_start [2][SLOTS];
  int unsigned rec_len   [2][SLOTS];
  int unsigned oldest    [2];
  int unsigned live      [2];
  int unsigned used      [2];
  int unsigned ring_sz   [2];

  ring_req_t    pending_q  [$];
  ring_result_t expected_q [$];

  ring_req_t cur_req;
  bit        req_loaded;
  int        gap_left;
  int        stall_left;
  bit        src_idle;
  bit        snk_idle;
  int        accepted_cnt;
  int        retired_cnt;
  int        hold_at;
  int        err_cnt;
  int        cycle_cnt;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned round_len(int unsigned payload);
    return ((payload + HDR + ALIGN - 1) / ALIGN) * ALIGN;
  endfunction

  function automatic int unsigned slot_at(int v, int unsigned i);
    return (oldest[v] + i) % SLOTS;
  endfunction

  function automatic logic [OFS_W-1:0] name_at(int v, int unsigned slot);
    return OFS_W'(rec_start[v][slot] + HDR);
  endfunction

  // one request against model copy v; returns the result beat it should produce
  function automatic ring_result_t apply_request(int v, opcode_t op, logic [LEN_W-1:0] len,
                                                 logic [OFS_W-1:0] name);
    ring_result_t res;
    int unsigned  r, lim, head, ns, cand, start, s;
    bit           fits;
    res.status  = ST_OK;
    res.granted = '0;
    fits        = 1'b0;
    start       = 0;
    case (op)
      OP_ALLOC: begin
        r   = round_len(32'(len));
        lim = (ring_sz[v] < RING_CAP) ? ring_sz[v] : RING_CAP;
        if (live[v] >= SLOTS) begin
          fits = 1'b0;
        end else if (live[v] == 0) begin
          fits = (r <= lim);
        end else begin
          head = rec_start[v][oldest[v]];
          ns   = slot_at(v, live[v] - 1);
          cand = rec_start[v][ns] + rec_len[v][ns];
          // wrapped deque: the gap ends at the oldest start
          if (head > rec_start[v][ns]) begin
            if (cand + r <= head) begin
              fits  = 1'b1;
              start = cand;
            end
          end else if (cand + r <= lim) begin
            fits  = 1'b1;
            start = cand;
          end else if (r < head) begin
            fits  = 1'b1;
            start = 0;
          end
        end
        if (fits) begin
          s = slot_at(v, live[v]);
          rec_start[v][s] = start;
          rec_len[v][s]   = r;
          live[v]++;
          used[v] += r;
          res.granted = OFS_W'(start + HDR);
        end else begin
          res.status = ST_NO_SPACE;
        end
      end
      OP_SHRINK: begin
        if (live[v] == 0) begin
          res.status = ST_BAD_NAME;
        end else begin
          ns = slot_at(v, live[v] - 1);
          r  = round_len(32'(len));
          if (name_at(v, ns) != name) begin
            res.status = ST_BAD_NAME;
          end else if (r > rec_len[v][ns]) begin
            res.status = ST_GROWS;
          end else begin
            used[v] -= rec_len[v][ns] - r;
            rec_len[v][ns] = r;
          end
        end
      end
      OP_RELEASE: begin
        if (live[v] == 0) begin
          res.status = ST_BAD_NAME;
        end else begin
          ns = slot_at(v, live[v] - 1);
          // oldest end is matched first
          if (name_at(v, oldest[v]) == name) begin
            used[v] -= rec_len[v][oldest[v]];
            oldest[v] = slot_at(v, 1);
            live[v]--;
          end else if (name_at(v, ns) == name) begin
            used[v] -= rec_len[v][ns];
            live[v]--;
          end else begin
            res.status = ST_BAD_NAME;
          end
          if (live[v] == 0) oldest[v] = 0;
        end
      end
      default: ;
    endcase
    res.used  = SIZE_W'(used[v]);
    res.count = CNT_W'(live[v]);
    return res;
  endfunction

  // queue a beat for the driver and step the look-ahead copy
  function automatic ring_result_t plan_req(opcode_t op, int unsigned len, int unsigned name,
                                            bit drain_first = 1'b0);
    ring_req_t rq;
    rq.op          = op;
    rq.len         = LEN_W'(len);
    rq.name        = OFS_W'(name);
    rq.drain_first = drain_first;
    pending_q.push_back(rq);
    return apply_request(PLAN, rq.op, rq.len, rq.name);
  endfunction

  // payload name of the newest or oldest planned record; only called with records live
  function automatic logic [OFS_W-1:0] end_name(bit newest);
    return newest ? name_at(PLAN, slot_at(PLAN, live[PLAN] - 1)) : name_at(PLAN, oldest[PLAN]);
  endfunction

  function automatic int unsigned pick_len();
    case ($urandom_range(9, 0))
      0:       return $urandom_range(65535, 0);
      1:       return 65535;
      2:       return 0;
      3, 4:    return $urandom_range(2047, 0);
      default: return $urandom_range(200, 0);
    endcase
  endfunction

  // mostly well-formed requests on live records, the rest noise
  function automatic void plan_random_item(bit drain_first);
    int unsigned pick, ns, room, len;
    pick = $urandom_range(99, 0);
    if (live[PLAN] == 0 && pick >= 50 && pick < 90) pick = 0;
    if (pick < 50) begin
      void'(plan_req(OP_ALLOC, pick_len(), $urandom_range(65535, 0), drain_first));
    end else if (pick < 62) begin
      ns   = slot_at(PLAN, live[PLAN] - 1);
      room = rec_len[PLAN][ns] - HDR;
      if ($urandom_range(3, 0) == 0) begin
        len = room + $urandom_range(64, 1);
        if (len > 65535) len = 65535;
      end else begin
        len = $urandom_range(room, 0);
      end
      void'(plan_req(OP_SHRINK, len, 32'(name_at(PLAN, ns)), drain_first));
    end else if (pick < 90) begin
      void'(plan_req(OP_RELEASE, $urandom_range(65535, 0),
                     32'(end_name(1'($urandom_range(1, 0)))), drain_first));
    end else begin
      void'(plan_req(opcode_t'($urandom_range(3, 0)), $urandom_range(65535, 0),
                     $urandom_range(65535, 0), drain_first));
    end
  endfunction

  task automatic note_error(string msg);
    if (err_cnt < MAX_PRINTS) $display("ERROR result %0d: %s", retired_cnt, msg);
    err_cnt++;
  endtask

  task automatic check_field(string field, logic [31:0] got, logic [31:0] want);
    if (got !== want) note_error($sformatf("%s got 0x%0h expected 0x%0h", field, got, want));
  endtask

  // request driver: one planned beat at a time, random gap before each when source gaps are on
  always @(posedge clk) begin
    bit took;
    bit settled;
    if (!rst_n) begin
      in_ch.valid          <= 1'b0;
      in_ch.opcode         <= OP_ALLOC;
      in_ch.length         <= '0;
      in_ch.payload_offset <= '0;
      req_loaded = 1'b0;
      gap_left   = 0;
    end else begin
      took = in_ch.valid && in_ch.ready;
      if (took) req_loaded = 1'b0;
      settled = (accepted_cnt + int'(took)) == retired_cnt;
      if (!in_ch.valid || in_ch.ready) begin
        if (!req_loaded && pending_q.size() != 0 &&
            (!pending_q[0].drain_first || settled)) begin
          cur_req    = pending_q.pop_front();
          req_loaded = 1'b1;
          gap_left   = src_idle ? $urandom_range(15, 0) : 0;
        end
        if (req_loaded && gap_left == 0) begin
          in_ch.valid          <= 1'b1;
          in_ch.opcode         <= cur_req.op;
          in_ch.length         <= cur_req.len;
          in_ch.payload_offset <= cur_req.name;
        end else begin
          in_ch.valid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end
      end
    end
  end

  // monitor: checks result beats, predicts from accepted request beats, paces ready
  always @(posedge clk) begin
    ring_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      accepted_cnt <= 0;
      retired_cnt  <= 0;
      stall_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          note_error("result beat with nothing outstanding");
        end else begin
          want = expected_q.pop_front();
          check_field("status", 32'(out_ch.status), 32'(want.status));
          check_field("granted_offset", 32'(out_ch.granted_offset), 32'(want.granted));
          check_field("used_bytes", 32'(out_ch.used_bytes), 32'(want.used));
          check_field("record_count", 32'(out_ch.record_count), 32'(want.count));
        end
        retired_cnt <= retired_cnt + 1;
        stall_left = snk_idle ? $urandom_range(15, 0) : 0;
        // long hold-off so the block backs up into the request side
        if (retired_cnt + 1 == hold_at) stall_left = HOLD_CYCLES;
      end
      if (in_ch.valid && in_ch.ready) begin
        expected_q.push_back(apply_request(TRACK, opcode_t'(in_ch.opcode), in_ch.length,
                                           in_ch.payload_offset));
        accepted_cnt <= accepted_cnt + 1;
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_q.size() != 0 || req_loaded || in_ch.valid || retired_cnt < accepted_cnt);
  endtask

  task automatic set_ring_size(int unsigned val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= SIZE_W'(val);
    @(posedge clk);
    cfg_we    <= 1'b0;
    ring_sz[PLAN]  = val % (1 << SIZE_W);
    ring_sz[TRACK] = val % (1 << SIZE_W);
  endtask

  // new ring size on an idle block, live records kept, then a burst of random beats
  task automatic run_random_phase(int unsigned ring_bytes, int n_items, bit src_gaps,
                                  bit snk_gaps, bit hold);
    wait_idle();
    set_ring_size(ring_bytes);
    @(negedge clk);
    src_idle = src_gaps;
    snk_idle = snk_gaps;
    if (hold) hold_at = retired_cnt + 20;
    for (int i = 0; i < n_items; i++)
      plan_random_item(i == n_items / 2 || $urandom_range(49, 0) == 0);
  endtask

  initial begin
    ring_result_t g;
    int unsigned  a, b, c;
    cfg_we               = 1'b0;
    cfg_wdata            = '0;
    in_ch.valid          = 1'b0;
    in_ch.opcode         = OP_ALLOC;
    in_ch.length         = '0;
    in_ch.payload_offset = '0;
    out_ch.ready         = 1'b0;
    rst_n                = 1'b0;
    err_cnt              = 0;
    cycle_cnt            = 0;
    hold_at              = -1;
    src_idle             = 1'b1;
    snk_idle             = 1'b1;
    for (int v = 0; v < 2; v++) begin
      oldest[v]  = 0;
      live[v]    = 0;
      used[v]    = 0;
      ring_sz[v] = 32'(RING_SIZE_RST);
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty ring, ignored opcode, oversize, shrink and release paths
    void'(plan_req(OP_SHRINK, 0, HDR));
    void'(plan_req(OP_RELEASE, 0, HDR));
    void'(plan_req(OP_NONE, 65535, 65535));
    void'(plan_req(OP_ALLOC, 65535, 0));
    g = plan_req(OP_ALLOC, 0, 0);
    a = 32'(g.granted);
    g = plan_req(OP_ALLOC, 1, 0);
    b = 32'(g.granted);
    void'(plan_req(OP_SHRINK, 0, b));
    void'(plan_req(OP_SHRINK, 100, b));         // would grow
    void'(plan_req(OP_SHRINK, 0, a));           // oldest is not the newest
    void'(plan_req(OP_RELEASE, 0, 65535));      // names neither end
    void'(plan_req(OP_RELEASE, 0, b));
    void'(plan_req(OP_RELEASE, 0, a));
    g = plan_req(OP_ALLOC, 65504, 0);           // takes the whole ring
    a = 32'(g.granted);
    void'(plan_req(OP_ALLOC, 0, 0));
    void'(plan_req(OP_RELEASE, 0, a));
    // wrap to byte 0, including a size equal to the oldest start
    g = plan_req(OP_ALLOC, 32000, 0);
    a = 32'(g.granted);
    g = plan_req(OP_ALLOC, 32000, 0);
    b = 32'(g.granted);
    void'(plan_req(OP_RELEASE, 0, a));
    void'(plan_req(OP_ALLOC, 32000, 0));
    g = plan_req(OP_ALLOC, 2000, 0);
    a = 32'(g.granted);
    void'(plan_req(OP_ALLOC, 40000, 0));        // runs into the oldest record
    g = plan_req(OP_ALLOC, 29000, 0);
    c = 32'(g.granted);
    void'(plan_req(OP_RELEASE, 0, c));
    void'(plan_req(OP_RELEASE, 0, b));
    void'(plan_req(OP_RELEASE, 0, a));

    // random phases over several ring sizes
    run_random_phase(32, 40, 1'b1, 1'b1, 1'b0);        // smallest documented size
    run_random_phase(1024, 130, 1'b1, 1'b0, 1'b1);
    run_random_phase(4096, 130, 1'b0, 1'b1, 1'b0);
    run_random_phase(600, 90, 1'b0, 1'b0, 1'b0);       // not a multiple of the alignment
    run_random_phase(0, 25, 1'b1, 1'b1, 1'b0);         // below the minimum
    run_random_phase(131071, 90, 1'b1, 1'b1, 1'b0);    // above capacity, clipped
    run_random_phase(2048, 130, 1'b1, 1'b1, 1'b1);

    wait_idle();
    repeat (20) @(posedge clk);
    @(negedge clk);
    if (expected_q.size() != 0)
      note_error($sformatf("%0d results never arrived", expected_q.size()));
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
